[hdl/key_matrix_row_debouncer_defines.svh]
// Assertion macros shared by the debouncer RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef KEY_MATRIX_ROW_DEBOUNCER_DEFINES_SVH
`define KEY_MATRIX_ROW_DEBOUNCER_DEFINES_SVH

`ifndef ASSERT_OFF
// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/kmrd_pkg.sv]
`timescale 1ns / 1ps

package kmrd_pkg;

  // Matrix geometry.
  localparam int ROWS     = 8;
  localparam int ROW_BITS = 16;
  localparam int DEPTH    = 4;

  // Fixed field widths of the channels.
  localparam int OPCODE_W = 3;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 5;
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 16;

  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [ROW_BITS-1:0]  row_word_t;
  typedef row_word_t [DEPTH-1:0] hist_row_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [ROW_IDX_W-1:0] row_idx_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SCAN    = 3'd0,
    OP_READ    = 3'd1,
    OP_EXTRA   = 3'd2,
    OP_ONESHOT = 3'd3,
    OP_SLEEP   = 3'd4
  } op_t;

  // Fit a raw sample into a row word; bits at or above ROW_BITS are dropped.
  function automatic row_word_t fit_sample(input logic [SAMPLE_W-1:0] s);
    row_word_t w;
    w = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (i < SAMPLE_W) begin
        w[i] = s[i];
      end
    end
    return w;
  endfunction

  // Low output bits of a row word, zero above ROW_BITS.
  function automatic logic [OUT_W-1:0] fit_out(input row_word_t w);
    logic [OUT_W-1:0] o;
    o = '0;
    for (int i = 0; i < OUT_W; i++) begin
      if (i < ROW_BITS) begin
        o[i] = w[i];
      end
    end
    return o;
  endfunction

endpackage

[hdl/kmrd_item_if.sv]
`timescale 1ns / 1ps

// Command word channel into the debouncer.
interface kmrd_item_if;
  logic                          valid;
  logic                          ready;
  logic [kmrd_pkg::OPCODE_W-1:0] opcode;
  logic [kmrd_pkg::ROW_W-1:0]    row;
  logic [kmrd_pkg::COL_W-1:0]    col;
  logic [kmrd_pkg::SAMPLE_W-1:0] sample_bits;
  logic                          press;

  modport source (output valid, opcode, row, col, sample_bits, press, input ready);
  modport sink   (input valid, opcode, row, col, sample_bits, press, output ready);
endinterface

[hdl/kmrd_result_if.sv]
`timescale 1ns / 1ps

// Result word channel out of the debouncer.
interface kmrd_result_if;
  logic                       valid;
  logic                       ready;
  logic [kmrd_pkg::OUT_W-1:0] row_bits;
  logic                       accepted;

  modport source (output valid, row_bits, accepted, input ready);
  modport sink   (input valid, row_bits, accepted, output ready);
endinterface

[hdl/key_matrix_row_debouncer.sv]
`timescale 1ns / 1ps
// Key-matrix row debouncer.
// The item channel carries one command word: scan a row sample, read a merged
// row, press or release a virtual extra key, queue a one-shot key, or sleep.
// The result channel returns exactly one word per command: the debounced or
// merged row bits and an accepted flag (0 for ignored or out-of-range words).
// A key bit toggles only when all DEPTH stored samples of its row disagree
// with its current debounced value.
// A word passes through one input register and one result register, with all
// per-row state read and written between them. Throughput is one word per cycle
// while the receiver takes results, set by that single stage; back-to-back
// words to the same row see each other's updates without stalls.
// When the receiver stalls, the result register holds and the input register
// fills; further words are refused until the result is taken.
// Synchronous reset clears every sample ring, pointer, debounced row, extra and
// one-shot key, and the sleep flag, and empties both registers.
// Only reset leaves sleep mode.
`include "key_matrix_row_debouncer_defines.svh"

module key_matrix_row_debouncer (
  input  logic            clk,
  input  logic            rst,
  kmrd_item_if.sink       item,
  kmrd_result_if.source   result
);
  import kmrd_pkg::*;

  // Input register.
  logic                s1_valid;
  op_t                 s1_opcode;
  logic [ROW_W-1:0]    s1_row;
  logic [COL_W-1:0]    s1_col;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_press;

  // Result register.
  logic             o_valid;
  logic [OUT_W-1:0] o_row_bits;
  logic             o_accepted;

  // Per-row state.
  hist_row_t history   [ROWS];
  ptr_t      pointer   [ROWS];
  row_word_t debounced [ROWS];
  row_word_t extra     [ROWS];
  row_word_t oneshot   [ROWS];
  logic      pending   [ROWS];
  logic      sleeping;

  logic       advance;
  logic       row_ok;
  logic       col_ok;
  row_idx_t   ridx;
  row_word_t  sample_w;
  row_word_t  deb_cur;
  ptr_t       ptr_cur;
  ptr_t       ptr_next;
  hist_row_t  hist_next;
  row_word_t  flip;
  row_word_t  settled;
  row_word_t  col_bit;
  row_word_t  bits_next;
  logic       ok_next;

  // The stage moves when the result register is free or being emptied.
  assign advance    = s1_valid && (!o_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  assign result.valid    = o_valid;
  assign result.row_bits = o_row_bits;
  assign result.accepted = o_accepted;

  // Range checks and row selection.
  assign row_ok   = {1'b0, s1_row} < (ROW_W + 1)'(ROWS);
  assign col_ok   = {1'b0, s1_col} < (COL_W + 1)'(ROW_BITS);
  assign ridx     = s1_row[ROW_IDX_W-1:0];
  assign sample_w = fit_sample(s1_sample);
  assign deb_cur  = debounced[ridx];
  assign ptr_cur  = pointer[ridx];
  assign ptr_next = ({1'b0, ptr_cur} == (PTR_W + 1)'(DEPTH - 1)) ? '0 : ptr_cur + 1'b1;
  assign col_bit  = row_word_t'(1) << s1_col;

  // Ring with the new sample in place, then the all-disagree flip mask.
  always_comb begin
    hist_next = history[ridx];
    flip      = '1;
    for (int d = 0; d < DEPTH; d++) begin
      if (ptr_cur == PTR_W'(d)) begin
        hist_next[d] = sample_w;
      end
      flip = flip & (deb_cur ^ hist_next[d]);
    end
    settled = deb_cur ^ flip;
  end

  // Result word for the command in the input register.
  always_comb begin
    bits_next = '0;
    ok_next   = 1'b0;
    case (s1_opcode)
      OP_SLEEP: begin
        ok_next = 1'b1;
      end
      OP_SCAN: begin
        if (row_ok && !sleeping) begin
          bits_next = settled;
          ok_next   = 1'b1;
        end
      end
      OP_READ: begin
        if (row_ok) begin
          bits_next = deb_cur | extra[ridx] | (pending[ridx] ? oneshot[ridx] : '0);
          ok_next   = 1'b1;
        end
      end
      OP_EXTRA, OP_ONESHOT: begin
        ok_next = row_ok && col_ok;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_opcode <= op_t'(item.opcode);
      s1_row    <= item.row;
      s1_col    <= item.col;
      s1_sample <= item.sample_bits;
      s1_press  <= item.press;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (advance) begin
      o_row_bits <= fit_out(bits_next);
      o_accepted <= ok_next;
    end
  end

  // State update, once per command as it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        history[r]   <= '0;
        pointer[r]   <= '0;
        debounced[r] <= '0;
        extra[r]     <= '0;
        oneshot[r]   <= '0;
        pending[r]   <= 1'b0;
      end
      sleeping <= 1'b0;
    end else if (advance) begin
      case (s1_opcode)
        OP_SLEEP: begin
          sleeping <= 1'b1;
        end
        OP_SCAN: begin
          if (row_ok && !sleeping) begin
            history[ridx]   <= hist_next;
            pointer[ridx]   <= ptr_next;
            debounced[ridx] <= settled;
          end
        end
        OP_READ: begin
          if (row_ok && pending[ridx]) begin
            oneshot[ridx] <= '0;
            pending[ridx] <= 1'b0;
          end
        end
        OP_EXTRA: begin
          if (row_ok && col_ok) begin
            extra[ridx] <= s1_press ? (extra[ridx] | col_bit) : (extra[ridx] & ~col_bit);
          end
        end
        OP_ONESHOT: begin
          if (row_ok && col_ok) begin
            oneshot[ridx] <= oneshot[ridx] | col_bit;
            pending[ridx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks on the datapath and sleep control.
  `ASSERT_IMPLIES(a_reject_zero, clk, rst, o_valid && !o_accepted, o_row_bits == '0)
  `ASSERT_NEXT(a_sleep_sticks, clk, rst, sleeping, sleeping)
  `ASSERT_NEXT(a_no_scan_asleep, clk, rst, advance && sleeping && s1_opcode == OP_SCAN, !o_accepted)
  `ASSERT_IMPLIES(a_ptr_range, clk, rst, s1_valid, {1'b0, ptr_cur} < (PTR_W + 1)'(DEPTH))

endmodule
